@@ design/jsu_pkg.sv @@
// types, constants and helper functions shared by the json string unescaper
package jsu_pkg;

    // which byte the scanner expects next
    typedef enum logic [3:0] {
        PH_QUOTE   = 4'd0,
        PH_TEXT    = 4'd1,
        PH_ESC     = 4'd2,
        PH_HEX     = 4'd3,
        PH_HIGH    = 4'd4,
        PH_HIGH_BS = 4'd5,
        PH_LOWHEX  = 4'd6
    } phase_t;

    // result kind carried with every output transfer
    typedef enum logic [2:0] {
        ST_BYTE  = 3'd0,
        ST_END   = 3'd1,
        ST_NOQ   = 3'd2,
        ST_BADE  = 3'd3,
        ST_BADH  = 3'd4,
        ST_UNTRM = 3'd5
    } status_t;

    localparam int MAX_RES = 4;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;

    // scanner state kept between input items
    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_accum;
        logic [1:0]  hex_count;
        logic [15:0] high_half;
    } scan_state_t;

    // one queued result
    typedef struct packed {
        logic [7:0] data;
        status_t    status;
    } res_entry_t;

    // all results caused by one input item, entry 0 goes out first
    typedef struct packed {
        logic [2:0]                   count;
        res_entry_t [MAX_RES-1:0]     entry;
    } res_group_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } hex_dig_t;

    typedef struct packed {
        logic [2:0]            len;
        logic [3:0][7:0]       bytes;
    } utf8_seq_t;

    // hex digit value of an ascii byte
    function automatic hex_dig_t hex_val(input logic [7:0] c);
        hex_dig_t r;
        r.ok    = 1'b1;
        r.digit = 4'd0;
        if (c inside {[8'h30:8'h39]})
            r.digit = 4'(c - 8'h30);
        else if (c inside {[8'h61:8'h66]})
            r.digit = 4'(c - 8'h57);
        else if (c inside {[8'h41:8'h46]})
            r.digit = 4'(c - 8'h37);
        else
            r.ok = 1'b0;
        return r;
    endfunction

    // utf-8 byte sequence of a code point, up to four bytes
    function automatic utf8_seq_t utf8_encode(input logic [20:0] cp);
        utf8_seq_t r;
        r.bytes = '0;
        if (cp < 21'h80) begin
            r.len      = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            r.len      = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.len      = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.len      = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

@@ design/jsu_decode.sv @@
// next-state and result-group logic for one input byte of the string scanner
module jsu_decode
    import jsu_pkg::*;
(
    input  scan_state_t st,
    input  logic        at_end,
    input  logic [7:0]  c,
    output scan_state_t st_next,
    output res_group_t  grp
);

    hex_dig_t    hv;
    logic [15:0] acc_sh;
    logic        acc_hi;
    logic        acc_lo;
    logic        esc_simple;
    logic [7:0]  esc_data;
    logic        enc_en;
    logic [20:0] enc_cp;
    utf8_seq_t   enc;
    logic        tail_v;
    logic [7:0]  tail_data;
    status_t     tail_st;
    logic [2:0]  enc_len;

    // hex digit shifted into the accumulator
    always_comb
    begin
        hv     = hex_val(c);
        acc_sh = {st.hex_accum[11:0], hv.digit};
        acc_hi = (acc_sh >= SURR_HI_MIN) && (acc_sh <= SURR_HI_MAX);
        acc_lo = (acc_sh >= SURR_LO_MIN) && (acc_sh <= SURR_LO_MAX);
    end

    // simple escape letters
    always_comb
    begin
        esc_simple = 1'b1;
        esc_data   = c;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_data = c;
            8'h62:   esc_data = 8'h08;
            8'h66:   esc_data = 8'h0C;
            8'h6E:   esc_data = 8'h0A;
            8'h72:   esc_data = 8'h0D;
            8'h74:   esc_data = 8'h09;
            default: esc_simple = 1'b0;
        endcase
    end

    // phase transitions, an optional code point and an optional trailing result
    always_comb
    begin
        st_next   = st;
        enc_en    = 1'b0;
        enc_cp    = CP_REPLACE;
        tail_v    = 1'b0;
        tail_data = 8'h00;
        tail_st   = ST_BYTE;
        case (st.phase)
            PH_QUOTE:
            begin
                if (at_end || c != CH_QUOTE)
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_NOQ;
                end else
                    st_next.phase = PH_TEXT;
            end
            PH_TEXT, PH_HIGH:
            begin
                // a pending high surrogate that is not followed by a backslash
                if (st.phase == PH_HIGH && !(!at_end && c == CH_BSLASH))
                    enc_en = 1'b1;
                if (at_end)
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_UNTRM;
                    st_next.phase = PH_QUOTE;
                end else if (c == CH_QUOTE)
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_END;
                    st_next.phase = PH_QUOTE;
                end else if (c == CH_BSLASH)
                    st_next.phase = (st.phase == PH_HIGH) ? PH_HIGH_BS : PH_ESC;
                else
                begin
                    tail_v    = 1'b1;
                    tail_data = c;
                    st_next.phase = PH_TEXT;
                end
            end
            PH_ESC, PH_HIGH_BS:
            begin
                // escape after a high surrogate that is not a unicode escape
                if (st.phase == PH_HIGH_BS && !(!at_end && c == CH_LOW_U))
                    enc_en = 1'b1;
                if (at_end)
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_UNTRM;
                    st_next.phase = PH_QUOTE;
                end else if (c == CH_LOW_U)
                begin
                    st_next.hex_accum = '0;
                    st_next.hex_count = '0;
                    st_next.phase = (st.phase == PH_HIGH_BS) ? PH_LOWHEX : PH_HEX;
                end else if (esc_simple)
                begin
                    tail_v    = 1'b1;
                    tail_data = esc_data;
                    st_next.phase = PH_TEXT;
                end else
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_BADE;
                    st_next.phase = PH_QUOTE;
                end
            end
            PH_HEX, PH_LOWHEX:
            begin
                if (at_end)
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_UNTRM;
                    st_next.phase = PH_QUOTE;
                end else if (!hv.ok)
                begin
                    tail_v  = 1'b1;
                    tail_st = ST_BADH;
                    st_next.phase = PH_QUOTE;
                end else
                begin
                    st_next.hex_accum = acc_sh;
                    if (st.hex_count == 2'd3)
                    begin
                        st_next.hex_count = '0;
                        if (st.phase == PH_HEX)
                        begin
                            if (acc_hi)
                            begin
                                st_next.high_half = acc_sh;
                                st_next.phase     = PH_HIGH;
                            end else
                            begin
                                enc_en = 1'b1;
                                enc_cp = acc_lo ? CP_REPLACE : {5'd0, acc_sh};
                                st_next.phase = PH_TEXT;
                            end
                        end else
                        begin
                            // surrogate pair joins into a supplementary code point
                            enc_en = 1'b1;
                            enc_cp = acc_lo ?
                                SUPP_BASE + {1'b0, st.high_half[9:0], acc_sh[9:0]} :
                                CP_REPLACE;
                            st_next.phase = PH_TEXT;
                        end
                    end else
                        st_next.hex_count = st.hex_count + 2'd1;
                end
            end
            default:
            begin
                tail_v  = 1'b1;
                tail_st = ST_NOQ;
                st_next.phase = PH_QUOTE;
            end
        endcase
    end

    // pack encoded bytes then the trailing result into the group
    always_comb
    begin
        enc     = utf8_encode(enc_cp);
        enc_len = enc_en ? enc.len : 3'd0;
        grp.count = enc_len + {2'd0, tail_v};
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (3'(i) < enc_len)
            begin
                grp.entry[i].data   = enc.bytes[i];
                grp.entry[i].status = ST_BYTE;
            end else
            begin
                grp.entry[i].data   = tail_data;
                grp.entry[i].status = tail_st;
            end
        end
    end

endmodule

@@ design/jsu_outbuf.sv @@
// result register that hands out a queued result group one transfer at a time
module jsu_outbuf
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_group_t grp,
    output logic       room,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic [2:0] m_tuser,     // status
    output logic       m_tlast
);

    logic [2:0]               cnt_reg, cnt_next;
    res_entry_t [MAX_RES-1:0] ent_reg, ent_next;
    logic                     pop;

    assign pop      = (cnt_reg != 3'd0) && m_tready;
    assign room     = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tlast  = (cnt_reg == 3'd1);
    assign m_tdata  = ent_reg[0].data;
    assign m_tuser  = ent_reg[0].status;

    // load a new group or shift the queue on each transfer
    always_comb
    begin
        cnt_next = cnt_reg;
        ent_next = ent_reg;
        if (load)
        begin
            cnt_next = grp.count;
            ent_next = grp.entry;
        end else if (pop)
        begin
            cnt_next = cnt_reg - 3'd1;
            for (int i = 0; i < MAX_RES - 1; i++)
                ent_next[i] = ent_reg[i+1];
        end
    end

    // count under reset, entries are payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

@@ design/json_string_unescape_utf8_core.sv @@
// top level of the json quoted-string unescaper with utf-8 output
//
// Input stream: one raw byte of a quoted json string per transfer on s_*,
// s_tdata is the byte, s_tuser high marks end of input (byte ignored).
// Output stream: one result per transfer on m_*, m_tdata is a decoded utf-8
// byte, m_tuser the status (0 byte, 1 string end, 2 no opening quote,
// 3 bad escape, 4 bad hex, 5 unterminated), m_tlast marks the final result
// caused by one input transfer. Any status returns the scanner to waiting
// for an opening quote, so strings may follow one another.
// Results of an input transfer appear in the cycle after it is taken. An
// input transfer causes zero to four results; the result register drains
// one per cycle while m_tready is high, and a new input is taken while the
// last queued result goes out.
// Reset clears the scanner state and empties the result register.
// When the receiver stalls, the queued results hold and s_tready drops
// once the queue is not about to empty.
module json_string_unescape_utf8_core
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // in_byte
    input  logic       s_tuser,     // action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // out_byte
    output logic [2:0] m_tuser,     // status
    output logic       m_tlast
);

    scan_state_t st_reg, st_next, st_dec;
    res_group_t  grp;
    logic        room;
    logic        accept;
    logic        load;

    assign s_tready = room;
    assign accept   = s_tvalid && room;
    assign load     = accept && (grp.count != 3'd0);

    // per-byte decode
    jsu_decode u_decode (
        .st      (st_dec),
        .at_end  (s_tuser),
        .c       (s_tdata),
        .st_next (st_next),
        .grp     (grp)
    );

    assign st_dec = st_reg;

    // result queue toward the output stream
    jsu_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .grp      (grp),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // scanner state advances on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase     <= PH_QUOTE;
            st_reg.hex_accum <= '0;
            st_reg.hex_count <= '0;
            st_reg.high_half <= '0;
        end else if (accept)
            st_reg <= st_next;
    end

    // status results only close a group
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_BYTE) |-> m_tlast)
        else $error("status result not last in its group");

    // input is taken only when the queue is empty or draining its last result
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || (m_tlast && m_tready)))
        else $error("input accepted while results still queued");

    // end of input before the opening quote reports a missing quote
    a_noquote: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && st_reg.phase == PH_QUOTE && s_tuser)
        |=> (m_tvalid && m_tlast && m_tuser == ST_NOQ))
        else $error("missing opening quote not reported");

    // scanner phase stays within the defined set
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase <= PH_LOWHEX)
        else $error("scanner phase out of range");

endmodule

@@ bench/json_string_unescape_utf8_core_tb.sv @@
// self-checking testbench for the json string unescaper with utf-8 output
`timescale 1ns / 100ps

module json_string_unescape_utf8_core_tb
    import jsu_pkg::*;
();

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   DRAIN_CYCLES = 8;

    // one decoded result as it should leave the block
    typedef struct {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } utf8_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    // scanner state mirrored by the decoder model
    phase_t      scan_phase = PH_QUOTE;
    logic [15:0] hex_acc = '0;
    logic [1:0]  hex_cnt = '0;
    logic [15:0] high_half = '0;

    utf8_result_t utf8_expected[$];
    utf8_result_t step_results[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int items_sent = 0;

    logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};

    json_string_unescape_utf8_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    // digit value, or 16 when the byte is not a hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - "0");
        if (c >= "a" && c <= "f")
            return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F")
            return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    task automatic emit(input logic [7:0] b, input status_t st);
        utf8_result_t r;
        r.data   = b;
        r.status = st;
        r.last   = 1'b0;
        if (step_results.size() < MAX_RES)
            step_results.insert(step_results.size(), r);
    endtask

    // every status sends the scanner back to the opening quote
    task automatic emit_status(input status_t st);
        emit(8'h00, st);
        scan_phase = PH_QUOTE;
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80)
            emit(cp[7:0], ST_BYTE);
        else if (cp < 21'h800)
        begin
            emit({3'b110, cp[10:6]}, ST_BYTE);
            emit({2'b10, cp[5:0]}, ST_BYTE);
        end
        else if (cp < 21'h10000)
        begin
            emit({4'b1110, cp[15:12]}, ST_BYTE);
            emit({2'b10, cp[11:6]}, ST_BYTE);
            emit({2'b10, cp[5:0]}, ST_BYTE);
        end
        else
        begin
            emit({5'b11110, cp[20:18]}, ST_BYTE);
            emit({2'b10, cp[17:12]}, ST_BYTE);
            emit({2'b10, cp[11:6]}, ST_BYTE);
            emit({2'b10, cp[5:0]}, ST_BYTE);
        end
    endtask

    task automatic text_char(input logic [7:0] c);
        if (c == CH_QUOTE)
            emit_status(ST_END);
        else if (c == CH_BSLASH)
            scan_phase = PH_ESC;
        else
            emit(c, ST_BYTE);
    endtask

    task automatic escape_char(input logic [7:0] c);
        logic [7:0] v;
        case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: v = c;
            "b":     v = 8'h08;
            "f":     v = 8'h0C;
            "n":     v = 8'h0A;
            "r":     v = 8'h0D;
            "t":     v = 8'h09;
            CH_LOW_U:
            begin
                hex_acc    = '0;
                hex_cnt    = '0;
                scan_phase = PH_HEX;
                return;
            end
            default:
            begin
                emit_status(ST_BADE);
                return;
            end
        endcase
        emit(v, ST_BYTE);
        scan_phase = PH_TEXT;
    endtask

    // shift one hex digit in, done is set on the fourth
    task automatic hex_take(input logic [7:0] c, output logic done);
        logic [4:0] d;
        d    = hex_nibble(c);
        done = 1'b0;
        if (d[4])
            emit_status(ST_BADH);
        else
        begin
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_cnt == 2'd3)
            begin
                hex_cnt = '0;
                done    = 1'b1;
            end
            else
                hex_cnt = hex_cnt + 2'd1;
        end
    endtask

    function automatic logic is_high(input logic [15:0] v);
        return v >= SURR_HI_MIN && v <= SURR_HI_MAX;
    endfunction

    function automatic logic is_low(input logic [15:0] v);
        return v >= SURR_LO_MIN && v <= SURR_LO_MAX;
    endfunction

    // expected results of one accepted input transfer
    task automatic unescape_byte(input logic act, input logic [7:0] c);
        logic done;
        step_results.delete();
        case (scan_phase)
            PH_QUOTE:
                if (act == ACT_END || c != CH_QUOTE)
                    emit_status(ST_NOQ);
                else
                    scan_phase = PH_TEXT;
            PH_TEXT:
                if (act == ACT_END)
                    emit_status(ST_UNTRM);
                else
                    text_char(c);
            PH_ESC:
                if (act == ACT_END)
                    emit_status(ST_UNTRM);
                else
                    escape_char(c);
            PH_HEX:
                if (act == ACT_END)
                    emit_status(ST_UNTRM);
                else
                begin
                    hex_take(c, done);
                    if (done)
                    begin
                        if (is_high(hex_acc))
                        begin
                            high_half  = hex_acc;
                            scan_phase = PH_HIGH;
                        end
                        else
                        begin
                            if (is_low(hex_acc))
                                emit_code_point(CP_REPLACE);
                            else
                                emit_code_point({5'b0, hex_acc});
                            scan_phase = PH_TEXT;
                        end
                    end
                end
            PH_HIGH:
                if (act == ACT_END)
                begin
                    emit_code_point(CP_REPLACE);
                    emit_status(ST_UNTRM);
                end
                else if (c == CH_BSLASH)
                    scan_phase = PH_HIGH_BS;
                else
                begin
                    emit_code_point(CP_REPLACE);
                    scan_phase = PH_TEXT;
                    text_char(c);
                end
            PH_HIGH_BS:
                if (act == ACT_END)
                begin
                    emit_code_point(CP_REPLACE);
                    emit_status(ST_UNTRM);
                end
                else if (c == CH_LOW_U)
                begin
                    hex_acc    = '0;
                    hex_cnt    = '0;
                    scan_phase = PH_LOWHEX;
                end
                else
                begin
                    emit_code_point(CP_REPLACE);
                    escape_char(c);
                end
            PH_LOWHEX:
                if (act == ACT_END)
                    emit_status(ST_UNTRM);
                else
                begin
                    hex_take(c, done);
                    if (done)
                    begin
                        if (is_low(hex_acc))
                            emit_code_point(SUPP_BASE + (21'(high_half[9:0]) << 10)
                                            + 21'(hex_acc[9:0]));
                        else
                            emit_code_point(CP_REPLACE);
                        scan_phase = PH_TEXT;
                    end
                end
            default:
                emit_status(ST_NOQ);
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
            utf8_expected.insert(utf8_expected.size(), step_results[i]);
    endtask

    // ---------------------------------------------------------------
    // output side: random stall and result check
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        utf8_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (utf8_expected.size() == 0)
            begin
                $error("unexpected result: out_byte %0h status %0d last %0d",
                       m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end
            else
            begin
                exp_res = utf8_expected.pop_front();
                if (m_tdata !== exp_res.data)
                begin
                    $error("out_byte: expected %0h, actual %0h", exp_res.data, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_res.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== exp_res.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_res.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // one input transfer, with a random gap ahead of it
    task automatic send_item(input logic act, input logic [7:0] b);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < snd_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= act;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        unescape_byte(act, b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(ACT_DATA, s[i]);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
        if (d < 10)
            return 8'("0" + d);
        return upper ? 8'("A" + d - 10) : 8'("a" + d - 10);
    endfunction

    // backslash-u and four digits in random letter case
    task automatic send_u_escape(input logic [15:0] v);
        send_text("\\u");
        for (int i = 3; i >= 0; i--)
            send_item(ACT_DATA, hex_char(v[i*4 +: 4], 1'($urandom_range(1))));
    endtask

    function automatic logic is_escape_letter(input logic [7:0] c);
        foreach (esc_letters[i])
            if (esc_letters[i] == c)
                return 1'b1;
        return c == CH_LOW_U;
    endfunction

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] rand_bad_escape();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (is_escape_letter(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_bad_hex();
        logic [7:0] b;
        logic [4:0] d;
        do
        begin
            b = 8'($urandom_range(255));
            d = hex_nibble(b);
        end
        while (!d[4]);
        return b;
    endfunction

    function automatic logic [15:0] rand_not_low();
        logic [15:0] v;
        do
            v = 16'($urandom_range(16'hFFFF));
        while (is_low(v));
        return v;
    endfunction

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    // opening quote, empty string, raw bytes, end inside text
    task automatic test_quote_framing();
        send_item(ACT_END, 8'h00);
        send_item(ACT_DATA, "x");
        send_text("\"\"");
        send_item(ACT_DATA, CH_QUOTE);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'h80);
        send_item(ACT_DATA, 8'h7F);
        send_item(ACT_END, 8'hFF);
    endtask

    // all simple escapes, end inside an escape, unknown escape letter
    task automatic test_simple_escapes();
        send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\\");
        send_item(ACT_END, 8'h00);
        send_text("\"\\q");
    endtask

    // one, two and three byte code points, bad digit, end inside digits
    task automatic test_unicode_escapes();
        send_text("\"\\u0041\\u00e9\\uFfFf\\u0000\\u12g");
        send_text("\"\\u12");
        send_item(ACT_END, 8'h00);
    endtask

    // pairs, a lone low surrogate and high surrogates with wrong follow-ups
    task automatic test_surrogates();
        send_text("\"\\uD83D\\ude00\\uDBFF\\uDFFF\\uDC00");
        send_text("\\uD800x\\uDBFF\\n\\uD800\\u0041\\uD800\"");
        send_text("\"\\uD800");
        send_item(ACT_END, 8'h00);
        send_text("\"\\uD800\\");
        send_item(ACT_END, 8'h00);
        send_text("\"\\uD800\\u00");
        send_item(ACT_END, 8'h00);
        send_text("\"\\uD800\\z");
    endtask

    // ---------------------------------------------------------------
    // random strings: mostly well formed, some noise and broken endings
    // ---------------------------------------------------------------
    task automatic send_random_string();
        int n_tokens;
        int pick;
        int n_digits;
        if ($urandom_range(99) < 10)
        begin
            if ($urandom_range(1))
                send_item(ACT_END, 8'($urandom_range(255)));
            else
                send_item(ACT_DATA, rand_plain());
        end
        send_item(ACT_DATA, CH_QUOTE);
        n_tokens = $urandom_range(8);
        repeat (n_tokens)
        begin
            pick = $urandom_range(9);
            case (pick)
                0, 1, 2: send_item(ACT_DATA, rand_plain());
                3:
                begin
                    send_item(ACT_DATA, CH_BSLASH);
                    send_item(ACT_DATA, esc_letters[$urandom_range(7)]);
                end
                4: send_u_escape(16'($urandom_range(16'hFFFF)));
                5: send_u_escape(16'($urandom_range(16'h07FF)));
                6:
                begin
                    send_u_escape(16'(SURR_HI_MIN + $urandom_range(16'h3FF)));
                    send_u_escape(16'(SURR_LO_MIN + $urandom_range(16'h3FF)));
                end
                7:
                begin
                    // high surrogate with a wrong follow-up
                    send_u_escape(16'(SURR_HI_MIN + $urandom_range(16'h3FF)));
                    case ($urandom_range(2))
                        0: send_item(ACT_DATA, rand_plain());
                        1:
                        begin
                            send_item(ACT_DATA, CH_BSLASH);
                            send_item(ACT_DATA, esc_letters[$urandom_range(7)]);
                        end
                        default: send_u_escape(rand_not_low());
                    endcase
                end
                default: send_u_escape(16'(SURR_LO_MIN + $urandom_range(16'h3FF)));
            endcase
        end
        // string ending
        pick = $urandom_range(99);
        if (pick < 80)
            send_item(ACT_DATA, CH_QUOTE);
        else if (pick < 88)
            send_item(ACT_END, 8'($urandom_range(255)));
        else if (pick < 94)
        begin
            send_item(ACT_DATA, CH_BSLASH);
            send_item(ACT_DATA, rand_bad_escape());
        end
        else
        begin
            send_text("\\u");
            n_digits = $urandom_range(3);
            repeat (n_digits)
                send_item(ACT_DATA, hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
            send_item(ACT_DATA, rand_bad_hex());
        end
    endtask

    task automatic test_random_strings(input int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
            send_random_string();
    endtask

    // ---------------------------------------------------------------
    // sequence of tests
    // ---------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 32;
        rcv_idle_pct = 69;
        test_quote_framing();
        test_simple_escapes();
        test_unicode_escapes();
        test_surrogates();
        test_random_strings(75);

        snd_idle_pct = 69;
        rcv_idle_pct = 32;
        test_random_strings(75);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random_strings(75);
        s_tvalid <= 1'b0;

        // drain outstanding results
        while (utf8_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
